// ===== design/gssf_pkg.sv =====
// ----------------------------------------------------------------------------
// gssf_pkg
// Shared types and constants of the 3x3 grey smoothing / sharpening filter.
// ----------------------------------------------------------------------------
package gssf_pkg;

    // pixel and register widths
    localparam int GREY_W  = 8;
    localparam int MODE_W  = 2;
    localparam int LW_W    = 12;
    localparam int ROW_W   = 13;
    localparam int GAIN_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // frame geometry limits
    localparam int W_MIN = 3;
    localparam int H_MIN = 3;
    localparam int H_MAX = 4096;

    // filter mode codes
    localparam logic [MODE_W-1:0] MODE_SMOOTH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LAPLACE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNSHARP = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAPLACE_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNSHARP_GAIN = 3'd4;

    // control flags carried by the window stage
    typedef struct packed {
        logic shift;      // shift window and write line stores
        logic emit_edge;  // emit last column of an earlier row (old window center-right)
        logic emit_pix;   // emit the new window center
        logic border;     // new window center lies on the frame border
        logic last;       // final word of the frame
    } t_s1_ctrl;

endpackage

// ===== design/grey_3x3_smooth_sharpen_filter.sv =====
// pipeline: a word leaves via the window stage and the output register; a pixel's
// own result is produced by the accepted item line_width + 1 places later
// throughput: one item per cycle while the result stream does not stall, set by
// the line store, read at accept and written back when the window stage moves
// reset: synchronous active low; clears counters, window and handshake state
// and restores register defaults; the line stores are not cleared
// ----------------------------------------------------------------------------
// grey_3x3_smooth_sharpen_filter
// 3x3 grey filter on a raster pixel stream: binomial smoothing, Laplace
// sharpening or unsharp masking, with border pass-through and clamping.
// ----------------------------------------------------------------------------
module grey_3x3_smooth_sharpen_filter #(
    parameter int MAX_LINE = 2048
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_wr_en,
    input  logic [gssf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gssf_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // pixel input stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [gssf_pkg::GREY_W-1:0]        i_s_axis_tdata,  // [7:0] grey_in
    input  logic                               i_s_axis_tuser,  // [0] drain
    // result stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [gssf_pkg::GREY_W-1:0]        o_m_axis_tdata,  // [7:0] grey_out
    output logic                               o_m_axis_tlast   // frame_last
);

    localparam int GW = gssf_pkg::GREY_W;
    localparam int CW = $clog2(MAX_LINE);
    localparam int EW = (CW + 1 > gssf_pkg::LW_W) ? CW + 1 : gssf_pkg::LW_W;
    localparam int RW = gssf_pkg::ROW_W;

    // configuration registers
    logic [gssf_pkg::MODE_W-1:0]        r_filter_mode;
    logic [gssf_pkg::LW_W-1:0]          r_line_width;
    logic [RW-1:0]                      r_frame_height;
    logic signed [gssf_pkg::GAIN_W-1:0] r_laplace_gain;
    logic signed [gssf_pkg::GAIN_W-1:0] r_unsharp_gain;

    // position counters
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    // line stores: upper row in the high byte, lower row in the low byte
    logic [2*GW-1:0] r_mem [0:MAX_LINE-1];

    // window stage
    logic                 r_s1_valid;
    gssf_pkg::t_s1_ctrl   r_s1_ctrl;
    logic [GW-1:0]        r_s1_pix;
    logic [2*GW-1:0]      r_s1_rd;
    logic [CW-1:0]        r_s1_idx;
    logic [GW-1:0]        r_win [0:8];

    // output register
    logic          r_out_valid;
    logic [GW-1:0] r_out_data;
    logic          r_out_last;

    // accept side
    logic [EW-1:0] lw_ext;
    logic [EW-1:0] w_eff;
    logic [EW-1:0] col_ext;
    logic [EW-1:0] col_inc;
    logic [RW-1:0] h_eff;
    logic          drain_phase;
    logic          take;
    logic          load;
    logic          frame_end;
    logic          row_wrap;
    gssf_pkg::t_s1_ctrl n_ctrl;

    // window stage side
    logic          out_free;
    logic          s1_adv;
    logic [GW-1:0] n_win [0:8];
    logic [11:0]   sm_edge;
    logic [11:0]   sm_sum;
    logic [GW-1:0] smooth;
    logic signed [10:0] lap;
    logic signed [9:0]  diff;
    logic signed [10:0] mop;
    logic signed [gssf_pkg::GAIN_W-1:0] gain;
    logic signed [18:0] prod;
    logic signed [19:0] acc;
    logic [GW-1:0] sharp;
    logic [GW-1:0] filt;
    logic [GW-1:0] n_out_data;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode  <= gssf_pkg::MODE_SMOOTH;
            r_line_width   <= 12'd640;
            r_frame_height <= 13'd480;
            r_laplace_gain <= 8'sd1;
            r_unsharp_gain <= 8'sd1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                gssf_pkg::CFG_FILTER_MODE:  r_filter_mode  <= i_cfg_wdata[1:0];
                gssf_pkg::CFG_LINE_WIDTH:   r_line_width   <= i_cfg_wdata[11:0];
                gssf_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[12:0];
                gssf_pkg::CFG_LAPLACE_GAIN: r_laplace_gain <= $signed(i_cfg_wdata[7:0]);
                gssf_pkg::CFG_UNSHARP_GAIN: r_unsharp_gain <= $signed(i_cfg_wdata[7:0]);
                default: ;
            endcase
        end
    end

    // handshake: window stage moves when the output register is free
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign s1_adv          = r_s1_valid && out_free;
    assign o_s_axis_tready = !r_s1_valid || out_free;
    assign take            = i_s_axis_tvalid && o_s_axis_tready;

    // geometry saturation and item classification
    always_comb begin
        lw_ext  = EW'(r_line_width);
        if (lw_ext < EW'(gssf_pkg::W_MIN)) begin
            w_eff = EW'(gssf_pkg::W_MIN);
        end else if (lw_ext > EW'(MAX_LINE)) begin
            w_eff = EW'(MAX_LINE);
        end else begin
            w_eff = lw_ext;
        end
        if (r_frame_height < RW'(gssf_pkg::H_MIN)) begin
            h_eff = RW'(gssf_pkg::H_MIN);
        end else if (r_frame_height > RW'(gssf_pkg::H_MAX)) begin
            h_eff = RW'(gssf_pkg::H_MAX);
        end else begin
            h_eff = r_frame_height;
        end
        col_ext     = EW'(r_col);
        col_inc     = col_ext + EW'(1);
        drain_phase = r_row >= h_eff;
        // early drain is swallowed without effect
        load        = take && !(i_s_axis_tuser && !drain_phase);
        frame_end   = (r_col == '0) && (r_row >= h_eff + RW'(1));
        row_wrap    = col_inc >= w_eff;

        n_ctrl.shift     = !frame_end;
        n_ctrl.emit_edge = (r_col == '0) && (r_row >= RW'(2));
        n_ctrl.emit_pix  = (r_col != '0) && (r_row != '0);
        n_ctrl.last      = frame_end;
        n_ctrl.border    = (r_row == RW'(1)) || (r_row >= h_eff)
                        || (r_col == CW'(1)) || (col_ext >= w_eff);
    end

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (load) begin
            if (frame_end) begin
                r_col <= '0;
                r_row <= '0;
            end else if (row_wrap) begin
                r_col <= '0;
                r_row <= r_row + RW'(1);
            end else begin
                r_col <= col_inc[CW-1:0];
            end
        end
    end

    // line store: read at accept, write back when the window stage moves
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s1_rd <= r_mem[r_col];
        end
        if (s1_adv && r_s1_ctrl.shift) begin
            r_mem[r_s1_idx] <= {r_s1_rd[GW-1:0], r_s1_pix};
        end
    end

    // window stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s1_ctrl <= n_ctrl;
            r_s1_pix  <= drain_phase ? '0 : i_s_axis_tdata;
            r_s1_idx  <= r_col;
        end
    end

    // shifted window
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[i*3]   = r_win[i*3+1];
            n_win[i*3+1] = r_win[i*3+2];
        end
        n_win[2] = r_s1_rd[2*GW-1:GW];
        n_win[5] = r_s1_rd[GW-1:0];
        n_win[8] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_adv && r_s1_ctrl.shift) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

    // binomial sum, laplace sum and one shared gain multiply
    always_comb begin
        sm_edge = 12'(n_win[1]) + 12'(n_win[3]) + 12'(n_win[5]) + 12'(n_win[7]);
        sm_sum = 12'(n_win[0]) + 12'(n_win[2]) + 12'(n_win[6]) + 12'(n_win[8])
               + {sm_edge[10:0], 1'b0}
               + {2'b00, n_win[4], 2'b00};
        smooth = sm_sum[11:4];
        lap    = $signed(11'(n_win[1]) + 11'(n_win[3]) + 11'(n_win[5]) + 11'(n_win[7])
                         - {1'b0, n_win[4], 2'b00});
        diff   = $signed({2'b00, n_win[4]}) - $signed({2'b00, smooth});
        if (r_filter_mode == gssf_pkg::MODE_LAPLACE) begin
            mop  = lap;
            gain = r_laplace_gain;
        end else begin
            mop  = {diff[9], diff};
            gain = r_unsharp_gain;
        end
        prod = mop * gain;
        acc  = $signed({12'b0, n_win[4]}) + {prod[18], prod};
        // clamp to pixel range
        if (acc < 0) begin
            sharp = '0;
        end else if (acc > 20'sd255) begin
            sharp = '1;
        end else begin
            sharp = acc[GW-1:0];
        end
        case (r_filter_mode)
            gssf_pkg::MODE_LAPLACE: filt = sharp;
            gssf_pkg::MODE_UNSHARP: filt = sharp;
            default:                filt = smooth;
        endcase
        if (r_s1_ctrl.emit_edge) begin
            n_out_data = r_win[5];
        end else if (r_s1_ctrl.border) begin
            n_out_data = n_win[4];
        end else begin
            n_out_data = filt;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_adv && (r_s1_ctrl.emit_edge || r_s1_ctrl.emit_pix);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= n_out_data;
            r_out_last <= r_s1_ctrl.last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ===== design/gssf_checker.sv =====
// ----------------------------------------------------------------------------
// gssf_checker
// Port-level checks of the grey 3x3 filter, bound to the top level.
// ----------------------------------------------------------------------------
module gssf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_s_axis_tready,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [gssf_pkg::GREY_W-1:0] o_m_axis_tdata,
    input logic                        o_m_axis_tlast
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output word changed");

    // input side never blocks while the output can move
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_axis_tvalid || i_m_axis_tready) |-> o_s_axis_tready)
        else $error("input stalled with free output");

    // a frame's last word is never directly followed by another last word
    a_last_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast |=>
            !(o_m_axis_tvalid && o_m_axis_tlast))
        else $error("two frame ends in a row");

endmodule

bind grey_3x3_smooth_sharpen_filter gssf_checker u_gssf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ===== verif/grey_3x3_smooth_sharpen_filter_test.sv =====
// ----------------------------------------------------------------------------
// grey_3x3_smooth_sharpen_filter_test
// Streams raster frames through the 3x3 grey filter and checks every result
// word against an in-bench model of the window, line stores and filters.
// A short hand-built frame walks all four mode codes, an early drain and a
// late pixel; random frames follow with random geometry (out-of-range values
// too), gains with their extremes, pixel patterns and mid-frame geometry
// changes, while the sender bursts and the receiver stalls on patterns of
// their own.
// ----------------------------------------------------------------------------
module grey_3x3_smooth_sharpen_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LINE      = 2048;
    localparam int TARGET_WORDS  = 950;
    localparam int SETTLE_CYCLES = 6;
    localparam int END_CYCLES    = 20;

    // spare mode code, behaves as smoothing
    localparam logic [gssf_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef enum logic [1:0] {OP_WORD, OP_WRITE, OP_QUIESCE} t_stim_op;
    typedef enum logic [1:0] {PAT_NOISE, PAT_CHECKER, PAT_BINARY, PAT_RAMP} t_pix_pattern;
    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PULSE} t_rx_style;

    typedef struct {
        t_stim_op                        op;
        logic [gssf_pkg::GREY_W-1:0]     grey;
        logic                            drain;
        logic [gssf_pkg::CFG_IDX_W-1:0]  idx;
        logic [gssf_pkg::CFG_DATA_W-1:0] wdata;
    } t_stim_entry;

    typedef struct packed {
        logic [gssf_pkg::GREY_W-1:0] grey;
        logic                        last;
    } t_filt_word;

    logic                            i_clk;
    logic                            i_rst_n         = 1'b0;
    logic                            i_cfg_wr_en     = 1'b0;
    logic [gssf_pkg::CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [gssf_pkg::CFG_DATA_W-1:0] i_cfg_wdata     = '0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [gssf_pkg::GREY_W-1:0]     i_s_axis_tdata  = '0;  // [7:0] grey_in
    logic                            i_s_axis_tuser  = 1'b0; // [0] drain
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    logic [gssf_pkg::GREY_W-1:0]     o_m_axis_tdata;        // [7:0] grey_out
    logic                            o_m_axis_tlast;        // frame_last

    grey_3x3_smooth_sharpen_filter #(
        .MAX_LINE(MAX_LINE)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    // stimulus and scoreboard state
    t_stim_entry work_q[$];
    t_filt_word  expected_px[$];
    logic        in_fire     = 1'b0;
    bit          stim_done   = 1'b0;
    int          mismatches  = 0;
    int          words_sent  = 0;
    int          results_seen = 0;
    int          writes_done = 0;
    int          frames_queued = 0;
    int          midframe_changes = 0;
    int          stim_words  = 0;

    // model copy of the registers, at their reset values
    logic [gssf_pkg::MODE_W-1:0]        cur_mode   = gssf_pkg::MODE_SMOOTH;
    logic [gssf_pkg::LW_W-1:0]          cur_width  = 12'd640;
    logic [gssf_pkg::ROW_W-1:0]         cur_height = 13'd480;
    logic signed [gssf_pkg::GAIN_W-1:0] cur_lgain  = 8'sd1;
    logic signed [gssf_pkg::GAIN_W-1:0] cur_ugain  = 8'sd1;

    // model copy of line stores, window and raster position
    logic [gssf_pkg::GREY_W-1:0] upper_row [MAX_LINE];
    logic [gssf_pkg::GREY_W-1:0] lower_row [MAX_LINE];
    logic [gssf_pkg::GREY_W-1:0] win_px [9];
    int                          col_pos = 0;
    int                          row_pos = 0;

    initial begin
        for (int i = 0; i < MAX_LINE; i++) begin
            upper_row[i] = '0;
            lower_row[i] = '0;
        end
        for (int i = 0; i < 9; i++) win_px[i] = '0;
    end

    // clock and reset
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // geometry saturation
    function automatic int eff_width(input int w);
        if (w < gssf_pkg::W_MIN) return gssf_pkg::W_MIN;
        if (w > MAX_LINE) return MAX_LINE;
        return w;
    endfunction

    function automatic int eff_height(input int h);
        if (h < gssf_pkg::H_MIN) return gssf_pkg::H_MIN;
        if (h > gssf_pkg::H_MAX) return gssf_pkg::H_MAX;
        return h;
    endfunction

    function automatic logic [gssf_pkg::GREY_W-1:0] clamp_grey(input int v);
        if (v < 0) return '0;
        if (v > 255) return 8'd255;
        return v[gssf_pkg::GREY_W-1:0];
    endfunction

    // 1-2-1 binomial weighted sum over the window, divided by 16
    function automatic int smoothed_center();
        int corners, edges;
        corners = int'(win_px[0]) + int'(win_px[2]) + int'(win_px[6]) + int'(win_px[8]);
        edges   = int'(win_px[1]) + int'(win_px[3]) + int'(win_px[5]) + int'(win_px[7]);
        return (corners + 2 * edges + 4 * int'(win_px[4])) / 16;
    endfunction

    function automatic logic [gssf_pkg::GREY_W-1:0] filtered_center();
        int ctr, lap;
        ctr = int'(win_px[4]);
        case (cur_mode)
            gssf_pkg::MODE_LAPLACE: begin
                lap = int'(win_px[1]) + int'(win_px[7]) + int'(win_px[3])
                    + int'(win_px[5]) - 4 * ctr;
                return clamp_grey(ctr + int'(cur_lgain) * lap);
            end
            gssf_pkg::MODE_UNSHARP:
                return clamp_grey(ctr + int'(cur_ugain) * (ctr - smoothed_center()));
            default: return clamp_grey(smoothed_center());
        endcase
    endfunction

    // advance the raster model by one accepted word, queue the result it causes
    task automatic filter_pixel_step(input logic [gssf_pkg::GREY_W-1:0] grey,
                                     input logic drain);
        int          w, h, c, r, idx, cr, cc;
        logic        border;
        logic [gssf_pkg::GREY_W-1:0] pix;
        t_filt_word  res;
        w = eff_width(int'(cur_width));
        h = eff_height(int'(cur_height));
        c = col_pos;
        r = row_pos;
        // early drain is ignored
        if (drain && r < h) return;
        pix = (r >= h) ? '0 : grey;

        // last column of an earlier row leaves at the next row start
        if (c == 0 && r >= 2) begin
            res.grey = win_px[5];
            res.last = (r >= h + 1);
            expected_px.push_back(res);
            if (res.last) begin
                col_pos = 0;
                row_pos = 0;
                return;
            end
        end

        idx = (c < MAX_LINE) ? c : MAX_LINE - 1;
        for (int i = 0; i < 3; i++) begin
            win_px[i*3]     = win_px[i*3 + 1];
            win_px[i*3 + 1] = win_px[i*3 + 2];
        end
        win_px[2] = upper_row[idx];
        win_px[5] = lower_row[idx];
        win_px[8] = pix;
        upper_row[idx] = lower_row[idx];
        lower_row[idx] = pix;

        if (c >= 1 && r >= 1) begin
            cr = r - 1;
            cc = c - 1;
            border = (cr == 0) || (cr >= h - 1) || (cc == 0) || (cc >= w - 1);
            res.grey = border ? win_px[4] : filtered_center();
            res.last = 1'b0;
            expected_px.push_back(res);
        end

        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1) % 8192;
        end else begin
            col_pos = c + 1;
        end
    endtask

    task automatic apply_register(input logic [gssf_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [gssf_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            gssf_pkg::CFG_FILTER_MODE:  cur_mode   = data[gssf_pkg::MODE_W-1:0];
            gssf_pkg::CFG_LINE_WIDTH:   cur_width  = data[gssf_pkg::LW_W-1:0];
            gssf_pkg::CFG_FRAME_HEIGHT: cur_height = data[gssf_pkg::ROW_W-1:0];
            gssf_pkg::CFG_LAPLACE_GAIN: cur_lgain  = data[gssf_pkg::GAIN_W-1:0];
            gssf_pkg::CFG_UNSHARP_GAIN: cur_ugain  = data[gssf_pkg::GAIN_W-1:0];
            default: ;
        endcase
    endtask

    // stimulus builders
    task automatic push_word(input logic [gssf_pkg::GREY_W-1:0] g, input logic d);
        work_q.push_back('{op: OP_WORD, grey: g, drain: d, idx: '0, wdata: '0});
    endtask

    task automatic push_quiesce();
        work_q.push_back('{op: OP_QUIESCE, grey: '0, drain: 1'b0, idx: '0, wdata: '0});
    endtask

    task automatic push_write(input logic [gssf_pkg::CFG_IDX_W-1:0] idx, input int data);
        work_q.push_back('{op: OP_WRITE, grey: '0, drain: 1'b0, idx: idx,
                           wdata: data[gssf_pkg::CFG_DATA_W-1:0]});
    endtask

    task automatic queue_settings(input logic [gssf_pkg::MODE_W-1:0] mode,
                                  input int w, input int h,
                                  input logic [gssf_pkg::GAIN_W-1:0] lg,
                                  input logic [gssf_pkg::GAIN_W-1:0] ug);
        push_quiesce();
        push_write(gssf_pkg::CFG_FILTER_MODE, int'(mode));
        push_write(gssf_pkg::CFG_LINE_WIDTH, w);
        push_write(gssf_pkg::CFG_FRAME_HEIGHT, h);
        push_write(gssf_pkg::CFG_LAPLACE_GAIN, int'(lg));
        push_write(gssf_pkg::CFG_UNSHARP_GAIN, int'(ug));
    endtask

    function automatic logic [gssf_pkg::GREY_W-1:0] pick_grey(input t_pix_pattern pat,
                                                              input int col, input int row);
        case (pat)
            PAT_CHECKER: return ((col + row) % 2) ? 8'hFF : 8'h00;
            PAT_BINARY:  return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            PAT_RAMP:    return 8'((row * 37 + col * 11 + $urandom_range(0, 15)) % 256);
            default:     return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // gains lean on the extremes and on small factors that stay off the clamp
    function automatic logic [gssf_pkg::GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 6))
            0:       return 8'h80;
            1:       return 8'h7F;
            2:       return 8'h00;
            3:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(0, 8) - 4);
        endcase
    endfunction

    // pixel rows, with stray drain words and occasional full pauses
    task automatic queue_rows(input int w, input int first_row, input int end_row,
                              input t_pix_pattern pat, input bit noisy);
        for (int r = first_row; r < end_row; r++) begin
            for (int c = 0; c < w; c++) begin
                if (noisy && $urandom_range(0, 39) == 0)
                    push_word(8'($urandom_range(0, 255)), 1'b1);
                if (noisy && $urandom_range(0, 149) == 0)
                    push_quiesce();
                push_word(pick_grey(pat, c, r), 1'b0);
                stim_words++;
            end
        end
    endtask

    // flush words, some sent as late pixels
    task automatic queue_drains(input int w);
        for (int i = 0; i <= w; i++) begin
            push_word(8'($urandom_range(0, 255)), $urandom_range(0, 9) != 0);
            stim_words++;
        end
    endtask

    task automatic queue_frame(input int w_reg, input int h_reg, input t_pix_pattern pat);
        int w, h;
        w = eff_width(w_reg);
        h = eff_height(h_reg);
        queue_settings(2'($urandom_range(0, 3)), w_reg, h_reg, pick_gain(), pick_gain());
        queue_rows(w, 0, h, pat, 1'b1);
        queue_drains(w);
        frames_queued++;
    endtask

    // narrower rows and a new height from a row boundary on
    task automatic queue_split_frame(input t_pix_pattern pat);
        int w1, h1, k, w2, h2;
        w1 = $urandom_range(6, 14);
        h1 = $urandom_range(4, 8);
        k  = $urandom_range(2, h1 - 1);
        w2 = $urandom_range(3, w1 - 1);
        h2 = $urandom_range(k + 1, k + 4);
        queue_settings(2'($urandom_range(0, 3)), w1, h1, pick_gain(), pick_gain());
        queue_rows(w1, 0, k, pat, 1'b1);
        push_quiesce();
        push_write(gssf_pkg::CFG_LINE_WIDTH, w2);
        push_write(gssf_pkg::CFG_FRAME_HEIGHT, h2);
        queue_rows(w2, k, h2, pat, 1'b1);
        queue_drains(w2);
        frames_queued++;
        midframe_changes++;
    endtask

    // sender: bursts of words with random gaps, register writes when idle
    int burst_left   = 1;
    int gap_left     = 0;
    int quiet_cycles = 0;

    always @(negedge i_clk) begin : sender
        logic                            nxt_valid;
        logic [gssf_pkg::GREY_W-1:0]     nxt_grey;
        logic                            nxt_drain;
        logic                            nxt_we;
        logic [gssf_pkg::CFG_IDX_W-1:0]  nxt_idx;
        logic [gssf_pkg::CFG_DATA_W-1:0] nxt_wdata;
        nxt_valid = 1'b0;
        nxt_grey  = i_s_axis_tdata;
        nxt_drain = i_s_axis_tuser;
        nxt_we    = 1'b0;
        nxt_idx   = i_cfg_index;
        nxt_wdata = i_cfg_wdata;
        if (i_rst_n) begin
            if (in_fire) begin
                work_q.delete(0);
                words_sent++;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 64);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 :
                               $urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 4);
                end
            end
            if (i_s_axis_tvalid && !in_fire) begin
                // word still waiting for ready
                nxt_valid = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (work_q.size() != 0) begin
                case (work_q[0].op)
                    OP_WORD: begin
                        nxt_valid = 1'b1;
                        nxt_grey  = work_q[0].grey;
                        nxt_drain = work_q[0].drain;
                    end
                    OP_WRITE: begin
                        nxt_we    = 1'b1;
                        nxt_idx   = work_q[0].idx;
                        nxt_wdata = work_q[0].wdata;
                        apply_register(work_q[0].idx, work_q[0].wdata);
                        writes_done++;
                        work_q.delete(0);
                    end
                    default: begin
                        // hold until every result is back and the pipe has settled
                        quiet_cycles = (expected_px.size() == 0) ? quiet_cycles + 1 : 0;
                        if (quiet_cycles >= SETTLE_CYCLES) begin
                            quiet_cycles = 0;
                            work_q.delete(0);
                        end
                    end
                endcase
            end else begin
                stim_done = 1'b1;
            end
        end
        i_s_axis_tvalid <= nxt_valid;
        i_s_axis_tdata  <= nxt_grey;
        i_s_axis_tuser  <= nxt_drain;
        i_cfg_wr_en     <= nxt_we;
        i_cfg_index     <= nxt_idx;
        i_cfg_wdata     <= nxt_wdata;
    end

    // receiver: ready follows a changing stall style
    t_rx_style rx_style = RX_OPEN;
    int        rx_left  = 0;
    int        rx_tick  = 0;

    always @(negedge i_clk) begin : receiver
        logic rdy;
        if (rx_left == 0) begin
            rx_style = t_rx_style'($urandom_range(0, 3));
            rx_left  = $urandom_range(20, 200);
        end
        rx_left--;
        rx_tick++;
        case (rx_style)
            RX_OPEN:  rdy = 1'b1;
            RX_LIGHT: rdy = $urandom_range(0, 3) != 0;
            RX_HEAVY: rdy = $urandom_range(0, 3) == 0;
            default:  rdy = (rx_tick % 5) == 0;
        endcase
        i_m_axis_tready <= rdy;
    end

    // monitor: check result words first, then predict for the accepted input word
    always @(posedge i_clk) begin : monitor
        t_filt_word want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_px.size() == 0) begin
                    $error("unexpected result word: grey_out %0d frame_last %0b",
                           o_m_axis_tdata, o_m_axis_tlast);
                    mismatches++;
                end else begin
                    want = expected_px.pop_front();
                    results_seen++;
                    if (o_m_axis_tdata !== want.grey) begin
                        $error("grey_out: expected %0d, got %0d", want.grey, o_m_axis_tdata);
                        mismatches++;
                    end
                    if (o_m_axis_tlast !== want.last) begin
                        $error("frame_last: expected %0b, got %0b", want.last, o_m_axis_tlast);
                        mismatches++;
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready)
                filter_pixel_step(i_s_axis_tdata, i_s_axis_tuser);
            in_fire <= i_s_axis_tvalid && o_s_axis_tready;
        end
    end

    // stimulus plan and end of run
    initial begin : stimulus
        int fno;

        // hand-built 3x6 frame: one interior pixel per mode code, extreme gains
        queue_settings(gssf_pkg::MODE_SMOOTH, 3, 6, 8'h7F, 8'h80);
        push_word(8'hFF, 1'b1);
        queue_rows(3, 0, 3, PAT_CHECKER, 1'b0);
        push_quiesce();
        push_write(gssf_pkg::CFG_FILTER_MODE, int'(gssf_pkg::MODE_LAPLACE));
        queue_rows(3, 3, 4, PAT_CHECKER, 1'b0);
        push_quiesce();
        push_write(gssf_pkg::CFG_FILTER_MODE, int'(gssf_pkg::MODE_UNSHARP));
        queue_rows(3, 4, 5, PAT_CHECKER, 1'b0);
        push_quiesce();
        push_write(gssf_pkg::CFG_FILTER_MODE, int'(MODE_SPARE));
        queue_rows(3, 5, 6, PAT_CHECKER, 1'b0);
        push_word(8'hA5, 1'b0);
        repeat (3) push_word(8'h5A, 1'b1);
        frames_queued++;

        // random frames
        stim_words = 0;
        fno = 0;
        while (stim_words < TARGET_WORDS) begin
            fno++;
            if (fno % 7 == 3) begin
                queue_split_frame(t_pix_pattern'($urandom_range(0, 3)));
            end else begin
                queue_frame(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) :
                            ($urandom_range(0, 8) == 0) ? $urandom_range(11, 40) :
                                                          $urandom_range(3, 10),
                            ($urandom_range(0, 6) == 0) ? $urandom_range(0, 2) :
                                                          $urandom_range(3, 7),
                            t_pix_pattern'($urandom_range(0, 3)));
            end
        end

        while (!stim_done) @(posedge i_clk);
        while (expected_px.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);

        $display("run covered %0d input words in %0d frames, %0d of them resized mid-frame",
                 words_sent, frames_queued, midframe_changes);
        $display("%0d register writes, %0d result words checked, %0d mismatches",
                 writes_done, results_seen, mismatches);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin : watchdog
        #20ms;
        $display("timeout: %0d result words still expected", expected_px.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
